FILE: sv/spi_short_long_register_access_master_defines.svh
// ----------------------------------------------------------------------------
// SPI register access master: assertion macros
// Shared concurrent assertion forms used by the checker
// ----------------------------------------------------------------------------
`ifndef SPI_SHORT_LONG_REGISTER_ACCESS_MASTER_DEFINES_SVH
`define SPI_SHORT_LONG_REGISTER_ACCESS_MASTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SSLRA_ASSERT_SAME(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sslra assertion failed");

// next-cycle implication, disabled in reset
`define SSLRA_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sslra assertion failed");

`endif

FILE: sv/sslra_pkg.sv
// ----------------------------------------------------------------------------
// sslra_pkg
// Types and constants shared by the SPI register access master
// ----------------------------------------------------------------------------
package sslra_pkg;

    // request kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // access codes
    typedef enum logic [1:0] {
        ACC_SHORT_RD = 2'd0,
        ACC_SHORT_WR = 2'd1,
        ACC_LONG_RD  = 2'd2,
        ACC_LONG_WR  = 2'd3
    } access_t;

    // frame geometry
    localparam int FRAME_BITS = 24;
    localparam int COUNT_W    = 5;
    localparam int DATA_BITS  = 8;
    localparam int ADDR_BITS  = 10;
    localparam logic [COUNT_W-1:0] SHORT_FRAME_LEN = 5'd16;
    localparam logic [COUNT_W-1:0] LONG_FRAME_LEN  = 5'd24;

    // default depth of the command queue
    localparam int QUEUE_DEPTH = 2;

    // classified command handed from front to back
    typedef struct packed {
        logic                  is_start;
        logic [FRAME_BITS-1:0] frame;
        logic [COUNT_W-1:0]    bits;
        logic                  is_read;
        logic                  miso;
    } cmd_t;

endpackage

FILE: sv/sslra_front.sv
// ----------------------------------------------------------------------------
// sslra_front
// Classifies incoming requests and builds the serial frame for starts
// ----------------------------------------------------------------------------
module sslra_front
(
    input  logic                                   kind,
    input  logic [1:0]                             access,
    input  logic [sslra_pkg::ADDR_BITS-1:0]        address,
    input  logic [sslra_pkg::DATA_BITS-1:0]        write_data,
    input  logic                                   miso,
    output sslra_pkg::cmd_t                        cmd
);

    sslra_pkg::access_t                acc;
    logic                              rw;
    logic                              is_long;
    logic [sslra_pkg::DATA_BITS-1:0]   data;

    // decode access kind
    always_comb
    begin
        acc     = sslra_pkg::access_t'(access);
        rw      = acc inside {sslra_pkg::ACC_SHORT_WR, sslra_pkg::ACC_LONG_WR};
        is_long = acc inside {sslra_pkg::ACC_LONG_RD, sslra_pkg::ACC_LONG_WR};
        data    = rw ? write_data : '0;
    end

    // frame assembly, msb first
    always_comb
    begin
        cmd.is_start = (kind == sslra_pkg::KIND_START);
        cmd.miso     = miso;
        cmd.is_read  = !rw;
        if (is_long)
        begin
            cmd.frame = {1'b1, address, rw, {4{rw}}, data};
            cmd.bits  = sslra_pkg::LONG_FRAME_LEN;
        end
        else
        begin
            cmd.frame = {1'b0, address[5:0], rw, data, 8'h00};
            cmd.bits  = sslra_pkg::SHORT_FRAME_LEN;
        end
    end

endmodule

FILE: sv/sslra_fifo.sv
// ----------------------------------------------------------------------------
// sslra_fifo
// Short command queue between the front and back parts
// ----------------------------------------------------------------------------
module sslra_fifo
#(
    parameter int DEPTH = sslra_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sslra_pkg::cmd_t push_cmd,
    input  logic            pop,
    output sslra_pkg::cmd_t head_cmd,
    output logic            empty,
    output logic            full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    sslra_pkg::cmd_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == FULL_CNT);
    assign head_cmd = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: sv/sslra_back.sv
// ----------------------------------------------------------------------------
// sslra_back
// Runs the shift engine on queued commands and holds the result register
// ----------------------------------------------------------------------------
module sslra_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  sslra_pkg::cmd_t                   head_cmd,
    input  logic                              empty,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              chip_select_n,
    output logic                              clock_pulse,
    output logic                              mosi,
    output logic                              done_res,
    output logic [sslra_pkg::DATA_BITS-1:0]   read_data,
    output logic                              rejected
);

    localparam int FW = sslra_pkg::FRAME_BITS;
    localparam int DW = sslra_pkg::DATA_BITS;
    localparam int CW = sslra_pkg::COUNT_W;
    localparam logic [CW-1:0] DATA_LEN = CW'(DW);

    logic [FW-1:0] frame_shift_reg, frame_shift_next;
    logic [CW-1:0] bits_left_reg, bits_left_next;
    logic          busy_reg, busy_next;
    logic          is_read_reg, is_read_next;
    logic [DW-1:0] read_shift_reg, read_shift_next;
    logic          out_valid_reg, out_valid_next;

    logic          csn_reg, csn_next;
    logic          pulse_reg, pulse_next;
    logic          mosi_reg, mosi_next;
    logic          done_reg, done_next;
    logic [DW-1:0] rdata_reg, rdata_next;
    logic          rej_reg, rej_next;

    // take the next command when the result register is free
    assign pop       = !empty && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;

    // shift engine and result formation
    always_comb
    begin
        frame_shift_next = frame_shift_reg;
        bits_left_next   = bits_left_reg;
        busy_next        = busy_reg;
        is_read_next     = is_read_reg;
        read_shift_next  = read_shift_reg;
        csn_next         = 1'b1;
        pulse_next       = 1'b0;
        mosi_next        = 1'b0;
        done_next        = 1'b0;
        rdata_next       = '0;
        rej_next         = 1'b0;
        if (head_cmd.is_start)
        begin
            csn_next = 1'b0;
            if (busy_reg)
            begin
                rej_next = 1'b1;
            end
            else
            begin
                frame_shift_next = head_cmd.frame;
                bits_left_next   = head_cmd.bits;
                busy_next        = 1'b1;
                is_read_next     = head_cmd.is_read;
                read_shift_next  = '0;
            end
        end
        else if (busy_reg)
        begin
            csn_next         = 1'b0;
            pulse_next       = 1'b1;
            mosi_next        = frame_shift_reg[FW-1];
            frame_shift_next = {frame_shift_reg[FW-2:0], 1'b0};
            if (is_read_reg && (bits_left_reg <= DATA_LEN))
            begin
                read_shift_next = {read_shift_reg[DW-2:0], head_cmd.miso};
            end
            bits_left_next = bits_left_reg - 1'b1;
            if (bits_left_next == '0)
            begin
                done_next = 1'b1;
                busy_next = 1'b0;
                if (is_read_reg)
                begin
                    rdata_next = read_shift_next;
                end
            end
        end
    end

    // result register valid
    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    // engine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_shift_reg <= '0;
            bits_left_reg   <= '0;
            busy_reg        <= 1'b0;
            is_read_reg     <= 1'b0;
            read_shift_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                frame_shift_reg <= frame_shift_next;
                bits_left_reg   <= bits_left_next;
                busy_reg        <= busy_next;
                is_read_reg     <= is_read_next;
                read_shift_reg  <= read_shift_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            csn_reg   <= csn_next;
            pulse_reg <= pulse_next;
            mosi_reg  <= mosi_next;
            done_reg  <= done_next;
            rdata_reg <= rdata_next;
            rej_reg   <= rej_next;
        end
    end

    assign chip_select_n = csn_reg;
    assign clock_pulse   = pulse_reg;
    assign mosi          = mosi_reg;
    assign done_res      = done_reg;
    assign read_data     = rdata_reg;
    assign rejected      = rej_reg;

endmodule

FILE: sv/spi_short_long_register_access_master.sv
// ----------------------------------------------------------------------------
// spi_short_long_register_access_master
// SPI master for short and long register accesses: a start request loads a
// frame, each tick request shifts one bit out on mosi and samples miso
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_stall    kind, access, address, write_data, miso
//  out       out_valid / out_stall  chip_select_n, clock_pulse, mosi,
//                                   done_res, read_data, rejected
//
//  one request per cycle sustained while out_stall is low; each result
//  passes the command queue, then the result register, to the out port
//  the rate is set by the shift step in the back part
//  after reset the block is idle and accepts requests at once
//  out_stall holds the result register; in_stall rises once the queue is full
// ----------------------------------------------------------------------------
module spi_short_long_register_access_master
#(
    parameter int QUEUE_DEPTH = sslra_pkg::QUEUE_DEPTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic [1:0]                        access,
    input  logic [sslra_pkg::ADDR_BITS-1:0]   address,
    input  logic [sslra_pkg::DATA_BITS-1:0]   write_data,
    input  logic                              miso,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              chip_select_n,
    output logic                              clock_pulse,
    output logic                              mosi,
    output logic                              done_res,
    output logic [sslra_pkg::DATA_BITS-1:0]   read_data,
    output logic                              rejected
);

    sslra_pkg::cmd_t in_cmd;
    sslra_pkg::cmd_t head_cmd;
    logic            q_empty;
    logic            q_full;
    logic            q_pop;

    // request classification
    sslra_front u_front
    (
        .kind       (kind),
        .access     (access),
        .address    (address),
        .write_data (write_data),
        .miso       (miso),
        .cmd        (in_cmd)
    );

    // command queue
    sslra_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_valid && !q_full),
        .push_cmd (in_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    assign in_stall = q_full;

    // shift engine and result register
    sslra_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_cmd      (head_cmd),
        .empty         (q_empty),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .chip_select_n (chip_select_n),
        .clock_pulse   (clock_pulse),
        .mosi          (mosi),
        .done_res      (done_res),
        .read_data     (read_data),
        .rejected      (rejected)
    );

endmodule

FILE: sv/sslra_checker.sv
// ----------------------------------------------------------------------------
// sslra_checker
// Port-level checks on the SPI register access master results
// ----------------------------------------------------------------------------
`include "spi_short_long_register_access_master_defines.svh"

module sslra_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic                              chip_select_n,
    input  logic                              clock_pulse,
    input  logic                              mosi,
    input  logic                              done_res,
    input  logic [sslra_pkg::DATA_BITS-1:0]   read_data,
    input  logic                              rejected
);

    logic                              reject_quiet;
    logic                              done_ok;
    logic                              idle_quiet;
    logic [sslra_pkg::DATA_BITS+4:0]   res_bits;

    // result field groups
    assign reject_quiet = !chip_select_n && !clock_pulse && !done_res && !mosi;
    assign done_ok      = clock_pulse && !chip_select_n && !rejected;
    assign idle_quiet   = !mosi && !done_res && (read_data == '0);
    assign res_bits     = {chip_select_n, clock_pulse, mosi, done_res, read_data, rejected};

    // a rejected start keeps the frame open and produces nothing else
    `SSLRA_ASSERT_SAME(a_reject_quiet, clk, rst_n, out_valid && rejected, reject_quiet)

    // the last bit is a real clock pulse inside an open frame
    `SSLRA_ASSERT_SAME(a_done_pulse, clk, rst_n, out_valid && done_res, done_ok)

    // without a pulse the line and the read byte are quiet
    `SSLRA_ASSERT_SAME(a_no_pulse_quiet, clk, rst_n, out_valid && !clock_pulse, idle_quiet)

    // a stalled result is held
    `SSLRA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(res_bits))

endmodule

bind spi_short_long_register_access_master sslra_checker u_sslra_checker (.*);
